// ===== rtl/core/pftr_pkg.sv =====
`default_nettype none
package pftr_pkg;

  localparam int SCREEN_WIDTH  = 128;
  localparam int SCREEN_HEIGHT = 64;
  localparam int CHUNK_BYTES   = 16;

  localparam int PAGE_COUNT  = (SCREEN_HEIGHT + 7) / 8;
  localparam int STORE_BYTES = SCREEN_WIDTH * PAGE_COUNT;
  localparam int ADDR_W      = $clog2(STORE_BYTES);

  localparam int GLYPH_COLS = 5;
  localparam int GLYPH_ROWS = 7;
  localparam int SCALE      = 2;
  localparam int DRAW_COLS  = GLYPH_COLS * SCALE;
  localparam int SPAN_ROWS  = GLYPH_ROWS * SCALE;
  // rows of one drawn column, shifted by up to 7 inside the first page
  localparam int SPAN_PAGES = (SPAN_ROWS + 7 + 7) / 8;
  localparam int GLYPH_W    = GLYPH_COLS * GLYPH_ROWS;

  typedef enum logic [1:0] {
    OP_CLEAR = 2'd0,
    OP_DRAW  = 2'd1,
    OP_READ  = 2'd2,
    OP_NONE  = 2'd3
  } opcode_t;

  typedef struct packed {
    opcode_t     opcode;
    logic [7:0]  char_code;
    logic [11:0] origin_column;
    logic [7:0]  origin_row;
    logic [5:0]  chunk_index;
  } req_t;

  typedef struct packed {
    logic [63:0] chunk_low;
    logic [63:0] chunk_high;
    logic        done_res;
  } rsp_t;

  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [7:0]        wdata;
    logic [ADDR_W-1:0] raddr;
  } store_req_t;

  // glyph columns packed low to high, column 0 in bits 6..0
  function automatic logic [GLYPH_W-1:0] glyph_bits(input logic [7:0] code);
    logic [GLYPH_W-1:0] g;
    case (code)
      8'h52:   g = {7'h46, 7'h29, 7'h19, 7'h09, 7'h7f};
      8'h54:   g = {7'h01, 7'h01, 7'h7f, 7'h01, 7'h01};
      8'h68:   g = {7'h70, 7'h08, 7'h08, 7'h08, 7'h7f};
      8'h72:   g = {7'h08, 7'h04, 7'h04, 7'h08, 7'h7c};
      8'h65:   g = {7'h18, 7'h54, 7'h54, 7'h54, 7'h38};
      8'h61:   g = {7'h78, 7'h54, 7'h54, 7'h54, 7'h20};
      8'h64:   g = {7'h7f, 7'h48, 7'h44, 7'h44, 7'h38};
      default: g = '0;
    endcase
    return g;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/core/pftr_ram.sv =====
`default_nettype none
module pftr_ram #(
  parameter int ADDR_W = 10,
  parameter int DATA_W = 8
) (
  input  wire logic              clk,
  input  wire logic              we,
  input  wire logic [ADDR_W-1:0] waddr,
  input  wire logic [DATA_W-1:0] wdata,
  input  wire logic [ADDR_W-1:0] raddr,
  output logic      [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem [2**ADDR_W];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// ===== rtl/core/pftr_seq.sv =====
`default_nettype none
module pftr_seq (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 req_valid,
  output logic                      req_ready,
  input  wire pftr_pkg::req_t       req,
  output logic                      res_valid,
  input  wire logic                 res_ready,
  output pftr_pkg::rsp_t            res,
  output pftr_pkg::store_req_t      mem,
  input  wire logic [7:0]           rdata
);

  localparam int ADDR_W  = pftr_pkg::ADDR_W;
  localparam int DC_W    = $clog2(pftr_pkg::DRAW_COLS);
  localparam int PJ_W    = $clog2(pftr_pkg::SPAN_PAGES);
  localparam int GSEL_W  = $clog2(pftr_pkg::GLYPH_COLS);
  localparam int RK_W    = $clog2(pftr_pkg::CHUNK_BYTES);
  localparam int COL_W   = 13;
  localparam int PAGE_W  = 6;
  localparam int SPAN_W  = pftr_pkg::SPAN_PAGES * 8;
  localparam int DADDR_W = PAGE_W + $clog2(pftr_pkg::SCREEN_WIDTH) + 1;
  localparam int IDX_A   = $clog2(pftr_pkg::STORE_BYTES) + 1;
  localparam int IDX_B   = 6 + RK_W + 1;
  localparam int IDX_W   = (IDX_A > IDX_B) ? IDX_A : IDX_B;
  localparam int BUF_W   = pftr_pkg::CHUNK_BYTES * 8;

  typedef enum logic [2:0] {
    S_INIT,
    S_IDLE,
    S_CLEAR,
    S_DRAW,
    S_READ,
    S_FINISH
  } state_t;

  state_t                      state;
  logic [ADDR_W-1:0]           cnt;
  logic [DC_W-1:0]             dc;
  logic [PJ_W-1:0]             pj;
  logic [RK_W-1:0]             rk;
  logic [pftr_pkg::GLYPH_W-1:0] glyph;
  logic [11:0]                 ox;
  logic [7:0]                  oy;
  logic [5:0]                  chunk;
  logic                        pend_valid;
  logic [ADDR_W-1:0]           pend_addr;
  logic [7:0]                  pend_mask;
  logic                        cap_valid;
  logic                        cap_in;
  logic [BUF_W-1:0]            chunk_buf;
  logic                        done;

  logic [COL_W-1:0]   col;
  logic [PAGE_W-1:0]  page;
  logic [GSEL_W-1:0]  gsel;
  logic [6:0]         gcol;
  logic [SPAN_W-1:0]  span;
  logic [7:0]         mask_raw;
  logic [7:0]         mask;
  logic               col_ok;
  logic               draw_hit;
  logic [DADDR_W-1:0] daddr;
  logic [IDX_W-1:0]   idx;
  logic               in_range;

  function automatic logic [pftr_pkg::SPAN_ROWS-1:0] double_col(input logic [6:0] g);
    logic [pftr_pkg::SPAN_ROWS-1:0] d;
    for (int r = 0; r < pftr_pkg::GLYPH_ROWS; r++) begin
      for (int s = 0; s < pftr_pkg::SCALE; s++) begin
        d[r * pftr_pkg::SCALE + s] = g[r];
      end
    end
    return d;
  endfunction

  // one store byte per step: column dc of the cell, page pj below the origin page
  always_comb begin
    col      = COL_W'({1'b0, ox}) + COL_W'(dc);
    page     = PAGE_W'(oy[7:3]) + PAGE_W'(pj);
    gsel     = GSEL_W'(dc / pftr_pkg::SCALE);
    gcol     = glyph[gsel * pftr_pkg::GLYPH_ROWS +: 7];
    span     = SPAN_W'(double_col(gcol)) << oy[2:0];
    mask_raw = span[pj * 8 +: 8];
    for (int n = 0; n < 8; n++) begin
      mask[n] = mask_raw[n] &&
                ({page, 3'(n)} < (PAGE_W + 3)'(pftr_pkg::SCREEN_HEIGHT));
    end
    col_ok   = col < COL_W'(pftr_pkg::SCREEN_WIDTH);
    draw_hit = col_ok && (mask != 8'h00);
    daddr    = DADDR_W'(page) * DADDR_W'(pftr_pkg::SCREEN_WIDTH) + DADDR_W'(col);
    idx      = IDX_W'(chunk) * IDX_W'(pftr_pkg::CHUNK_BYTES) + IDX_W'(rk);
    in_range = idx < IDX_W'(pftr_pkg::STORE_BYTES);
  end

  always_comb begin
    if (state == S_INIT || state == S_CLEAR) begin
      mem.we    = 1'b1;
      mem.waddr = cnt;
      mem.wdata = 8'h00;
    end else begin
      mem.we    = pend_valid;
      mem.waddr = pend_addr;
      mem.wdata = rdata | pend_mask;
    end
    mem.raddr = (state == S_READ) ? idx[ADDR_W-1:0] : daddr[ADDR_W-1:0];
  end

  assign req_ready      = (state == S_IDLE);
  assign res_valid      = (state == S_FINISH) && !cap_valid;
  assign res.chunk_low  = chunk_buf[63:0];
  assign res.chunk_high = chunk_buf[BUF_W-1:64];
  assign res.done_res   = done;

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_INIT;
      cnt        <= '0;
      dc         <= '0;
      pj         <= '0;
      rk         <= '0;
      pend_valid <= 1'b0;
      cap_valid  <= 1'b0;
    end else begin
      // write back in the cycle after the read, while the next read goes out
      pend_valid <= (state == S_DRAW) && draw_hit;
      pend_addr  <= daddr[ADDR_W-1:0];
      pend_mask  <= mask;
      cap_valid  <= (state == S_READ);
      cap_in     <= in_range;
      if (cap_valid) begin
        chunk_buf <= {cap_in ? rdata : 8'h00, chunk_buf[BUF_W-1:8]};
      end

      unique case (state)
        S_INIT: begin
          if (cnt == ADDR_W'(pftr_pkg::STORE_BYTES - 1)) begin
            cnt   <= '0;
            state <= S_IDLE;
          end else begin
            cnt <= cnt + 1'b1;
          end
        end
        S_IDLE: begin
          if (req_valid) begin
            glyph     <= pftr_pkg::glyph_bits(req.char_code);
            ox        <= req.origin_column;
            oy        <= req.origin_row;
            chunk     <= req.chunk_index;
            chunk_buf <= '0;
            done      <= (req.opcode != pftr_pkg::OP_NONE);
            dc        <= '0;
            pj        <= '0;
            rk        <= '0;
            cnt       <= '0;
            unique case (req.opcode)
              pftr_pkg::OP_CLEAR: state <= S_CLEAR;
              pftr_pkg::OP_DRAW:  state <= S_DRAW;
              pftr_pkg::OP_READ:  state <= S_READ;
              pftr_pkg::OP_NONE:  state <= S_FINISH;
            endcase
          end
        end
        S_CLEAR: begin
          if (cnt == ADDR_W'(pftr_pkg::STORE_BYTES - 1)) begin
            cnt   <= '0;
            state <= S_FINISH;
          end else begin
            cnt <= cnt + 1'b1;
          end
        end
        S_DRAW: begin
          if (pj == PJ_W'(pftr_pkg::SPAN_PAGES - 1)) begin
            pj <= '0;
            if (dc == DC_W'(pftr_pkg::DRAW_COLS - 1)) begin
              state <= S_FINISH;
            end else begin
              dc <= dc + 1'b1;
            end
          end else begin
            pj <= pj + 1'b1;
          end
        end
        S_READ: begin
          rk <= rk + 1'b1;
          if (rk == RK_W'(pftr_pkg::CHUNK_BYTES - 1)) begin
            state <= S_FINISH;
          end
        end
        S_FINISH: begin
          if (res_valid && res_ready) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/page_framebuffer_text_render.sv =====
`default_nettype none
// channel   dir  handshake              payload
// req       in   req_valid / req_ready  pftr_pkg::req_t (opcode, char, origin, chunk)
// rsp       out  rsp_valid / rsp_ready  pftr_pkg::rsp_t (chunk_low, chunk_high, done_res)
//
// One item at a time. Draw takes 30 store steps (10 columns by 3 pages) pipelined
// through the read and write ports; read takes 16 byte reads; clear sweeps the
// store, one byte a cycle. After reset the same sweep runs before req_ready rises.
// The rsp register holds a result while the next item runs.
module page_framebuffer_text_render (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            req_valid,
  output logic                 req_ready,
  input  wire pftr_pkg::req_t  req,
  output logic                 rsp_valid,
  input  wire logic            rsp_ready,
  output pftr_pkg::rsp_t       rsp
);

  pftr_pkg::store_req_t mem;
  logic [7:0]           rdata;
  logic                 res_valid;
  logic                 res_ready;
  pftr_pkg::rsp_t       res;

  pftr_ram #(
    .ADDR_W (pftr_pkg::ADDR_W),
    .DATA_W (8)
  ) u_ram (
    .clk   (clk),
    .we    (mem.we),
    .waddr (mem.waddr),
    .wdata (mem.wdata),
    .raddr (mem.raddr),
    .rdata (rdata)
  );

  pftr_seq u_seq (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res),
    .mem       (mem),
    .rdata     (rdata)
  );

  assign res_ready = !rsp_valid || rsp_ready;

  // load a finished beat whenever the slot is free or being emptied
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (res_ready) begin
      rsp_valid <= res_valid;
      if (res_valid) begin
        rsp <= res;
      end
    end
  end

endmodule
`default_nettype wire
